@@ hdl/rmth_pkg.sv @@
`timescale 1ns / 1ps
package rmth_pkg;
  localparam int HEAP_DEPTH = 512;
  localparam int AW = $clog2(HEAP_DEPTH);
  localparam int CW = AW + 1;
  localparam int TW = AW + 2;
  localparam logic [TW-1:0] TOTAL_MAX = TW'(2 * HEAP_DEPTH);

  typedef enum logic [11:0] {
    S_IDLE   = 12'b000000000001,
    S_RDTOP  = 12'b000000000010,
    S_CHECK  = 12'b000000000100,
    S_DNRD   = 12'b000000001000,
    S_DNCMP  = 12'b000000010000,
    S_DNCMP2 = 12'b000000100000,
    S_PUSHRD = 12'b000001000000,
    S_PUSHCP = 12'b000010000000,
    S_TOPS   = 12'b000100000000,
    S_TOPS2  = 12'b001000000000,
    S_OUT    = 12'b010000000000,
    S_DNWR   = 12'b100000000000
  } state_t;

  // true when a must sit above b
  function automatic logic ranks_above(logic signed [31:0] a, logic signed [31:0] b,
                                       logic is_max);
    ranks_above = is_max ? (a > b) : (a < b);
  endfunction
endpackage

@@ hdl/running_median_two_heaps.sv @@
`timescale 1ns / 1ps
// Running median over up to 2*HEAP_DEPTH signed samples kept in two heaps in block
// memories (max-heap of the lower half, min-heap of the upper half). One sample is
// taken at a time; in_stall stays high while it is sorted in and until its result
// transfers. Each item checks the new sample against one heap top; if the top ranks above
// it, the sample takes the root and sinks level by level, and the displaced top then rises
// level by level in the other heap (else the sample rises there), one memory read and one
// comparator used per step. The result is held while out_stall is high. A full store drops
// the sample and raises overflow. No clearing pass is needed after reset.
module running_median_two_heaps (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_sample,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [32:0] out_median_doubled,
  output logic [10:0]        out_sample_count,
  output logic               out_overflow
);
  logic signed [31:0] mem_lo [rmth_pkg::HEAP_DEPTH];
  logic signed [31:0] mem_hi [rmth_pkg::HEAP_DEPTH];

  rmth_pkg::state_t state_r, state_nxt;
  logic [rmth_pkg::CW-1:0] lcnt_r, lcnt_nxt, ucnt_r, ucnt_nxt;
  logic signed [31:0] v_r, v_nxt, cur_r, cur_nxt, best_v_r, best_v_nxt;
  logic [rmth_pkg::CW-1:0] idx_r, idx_nxt, best_r, best_nxt;
  logic sel_r, sel_nxt;   // 1: lower (max) heap
  logic ovf_r, ovf_nxt;
  logic ov_r, ov_nxt;
  logic signed [32:0] med_r, med_nxt;
  logic [10:0] cnt_r, cnt_nxt;

  // one shared read address (both heaps read) and one write port, muxed between heaps
  logic          rd_en, wr_en, rd_sel, wr_sel;
  logic [rmth_pkg::AW-1:0] rd_addr, wr_addr;
  logic signed [31:0] wr_data, rd_lo, rd_hi, rd_q;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_lo <= mem_lo[rd_addr];
      rd_hi <= mem_hi[rd_addr];
    end
    if (wr_en && wr_sel) mem_lo[wr_addr] <= wr_data;
    if (wr_en && !wr_sel) mem_hi[wr_addr] <= wr_data;
  end
  assign rd_q = rd_sel ? rd_lo : rd_hi;
  assign rd_sel = sel_r;

  logic [rmth_pkg::CW-1:0] n_cur, child_l, child_r, parent;
  logic [rmth_pkg::TW-1:0] total;
  assign n_cur   = sel_r ? lcnt_r : ucnt_r;
  assign child_l = rmth_pkg::CW'({idx_r, 1'b1});
  assign child_r = rmth_pkg::CW'({idx_r, 1'b0}) + rmth_pkg::CW'(2);
  assign parent  = (idx_r - rmth_pkg::CW'(1)) >> 1;
  assign total   = rmth_pkg::TW'(lcnt_r) + rmth_pkg::TW'(ucnt_r);

  always_comb begin
    state_nxt = state_r; lcnt_nxt = lcnt_r; ucnt_nxt = ucnt_r; v_nxt = v_r;
    cur_nxt = cur_r; best_v_nxt = best_v_r; idx_nxt = idx_r;
    best_nxt = best_r; sel_nxt = sel_r; ovf_nxt = ovf_r; ov_nxt = ov_r;
    med_nxt = med_r; cnt_nxt = cnt_r;
    rd_en = 1'b0; rd_addr = '0; wr_en = 1'b0; wr_sel = sel_r; wr_addr = '0; wr_data = v_r;
    case (state_r)
      rmth_pkg::S_IDLE: begin
        if (in_valid) begin
          v_nxt = in_sample;
          ovf_nxt = (total >= rmth_pkg::TOTAL_MAX);
          sel_nxt = ~total[0];   // even: check against lower top
          state_nxt = ovf_nxt ? rmth_pkg::S_TOPS : rmth_pkg::S_RDTOP;
          rd_en = 1'b1;
        end
      end
      rmth_pkg::S_RDTOP: state_nxt = rmth_pkg::S_CHECK;
      rmth_pkg::S_CHECK: begin
        if (n_cur != '0 && rmth_pkg::ranks_above(rd_q, v_r, sel_r)) begin
          wr_en = 1'b1; wr_addr = '0; wr_data = v_r;
          cur_nxt = v_r; v_nxt = rd_q; idx_nxt = '0;
          state_nxt = rmth_pkg::S_DNRD;
        end else begin
          sel_nxt = ~sel_r;
          idx_nxt = sel_r ? ucnt_r : lcnt_r;
          state_nxt = rmth_pkg::S_PUSHCP;
        end
      end
      rmth_pkg::S_DNRD: begin
        best_nxt = idx_r; best_v_nxt = cur_r;
        if (child_l < n_cur) begin
          rd_en = 1'b1; rd_addr = child_l[rmth_pkg::AW-1:0];
          state_nxt = rmth_pkg::S_DNCMP;
        end else begin
          sel_nxt = ~sel_r;
          idx_nxt = sel_r ? ucnt_r : lcnt_r;
          state_nxt = rmth_pkg::S_PUSHCP;
        end
      end
      rmth_pkg::S_DNCMP: begin
        if (rmth_pkg::ranks_above(rd_q, best_v_r, sel_r)) begin
          best_nxt = child_l; best_v_nxt = rd_q;
        end
        if (child_r < n_cur) begin
          rd_en = 1'b1; rd_addr = child_r[rmth_pkg::AW-1:0];
          state_nxt = rmth_pkg::S_DNCMP2;
        end else begin
          state_nxt = rmth_pkg::S_DNCMP2;
          best_nxt = rmth_pkg::ranks_above(rd_q, best_v_r, sel_r) ? child_l : idx_r;
          idx_nxt = idx_r;
        end
      end
      rmth_pkg::S_DNCMP2: begin
        logic [rmth_pkg::CW-1:0] b;
        logic signed [31:0] bv;
        b = best_r; bv = best_v_r;
        if (child_r < n_cur && rmth_pkg::ranks_above(rd_q, best_v_r, sel_r)) begin
          b = child_r; bv = rd_q;
        end
        if (b == idx_r) begin
          sel_nxt = ~sel_r;
          idx_nxt = sel_r ? ucnt_r : lcnt_r;
          state_nxt = rmth_pkg::S_PUSHCP;
        end else begin
          wr_en = 1'b1; wr_addr = idx_r[rmth_pkg::AW-1:0]; wr_data = bv;
          idx_nxt = b;
          state_nxt = rmth_pkg::S_DNWR;
        end
      end
      rmth_pkg::S_DNWR: begin
        wr_en = 1'b1; wr_addr = idx_r[rmth_pkg::AW-1:0]; wr_data = cur_r;
        state_nxt = rmth_pkg::S_DNRD;
      end
      rmth_pkg::S_PUSHCP: begin
        // place v at idx, then sift up
        wr_en = 1'b1; wr_addr = idx_r[rmth_pkg::AW-1:0]; wr_data = v_r;
        if (idx_r == n_cur) begin
          if (sel_r) lcnt_nxt = lcnt_r + rmth_pkg::CW'(1);
          else ucnt_nxt = ucnt_r + rmth_pkg::CW'(1);
        end
        if (idx_r == '0) begin
          state_nxt = rmth_pkg::S_TOPS;
        end else begin
          rd_en = 1'b1; rd_addr = parent[rmth_pkg::AW-1:0];
          state_nxt = rmth_pkg::S_PUSHRD;
        end
      end
      rmth_pkg::S_PUSHRD: begin
        if (rmth_pkg::ranks_above(v_r, rd_q, sel_r)) begin
          wr_en = 1'b1; wr_addr = idx_r[rmth_pkg::AW-1:0]; wr_data = rd_q;
          idx_nxt = parent;
          state_nxt = rmth_pkg::S_PUSHCP;
        end else begin
          state_nxt = rmth_pkg::S_TOPS;
        end
      end
      rmth_pkg::S_TOPS: begin
        rd_en = 1'b1; rd_addr = '0;
        sel_nxt = 1'b1;
        state_nxt = rmth_pkg::S_TOPS2;
      end
      rmth_pkg::S_TOPS2: begin
        cnt_nxt = 11'(total);
        ov_nxt = ovf_r;
        if (total[0]) med_nxt = {rd_hi, 1'b0};
        else med_nxt = 33'(rd_lo) + 33'(rd_hi);
        state_nxt = rmth_pkg::S_OUT;
      end
      rmth_pkg::S_OUT: begin
        if (!out_stall) state_nxt = rmth_pkg::S_IDLE;
      end
      default: state_nxt = rmth_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rmth_pkg::S_IDLE;
      lcnt_r <= '0;
      ucnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      lcnt_r <= lcnt_nxt;
      ucnt_r <= ucnt_nxt;
    end
    v_r <= v_nxt; cur_r <= cur_nxt; best_v_r <= best_v_nxt;
    idx_r <= idx_nxt; best_r <= best_nxt; sel_r <= sel_nxt; ovf_r <= ovf_nxt;
    ov_r <= ov_nxt; med_r <= med_nxt; cnt_r <= cnt_nxt;
  end

  assign in_stall = (state_r != rmth_pkg::S_IDLE);
  assign out_valid = (state_r == rmth_pkg::S_OUT);
  assign out_median_doubled = med_r;
  assign out_sample_count = cnt_r;
  assign out_overflow = ov_r;
endmodule
